FILE: hdl/gf2eb_pkg.sv
// shared constants and controller/datapath interface types for the gf(2) echelon basis
`default_nettype none

package gf2eb_pkg;

  localparam int VEC_WIDTH_DEF = 32;
  localparam int OPERAND_W     = 32;
  localparam int RANK_W        = 6;
  localparam int REQ_W         = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic elim;
    logic clr;
    logic append;
    logic emit;
    logic add;
  } dp_cmd_t;

  typedef struct packed {
    logic res_zero;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/gf2eb_ctrl.sv
// sequencing state machine for the reduce and elimination passes
`default_nettype none

module gf2eb_ctrl
  import gf2eb_pkg::*;
#(
  parameter int VEC_WIDTH = VEC_WIDTH_DEF,
  localparam int CNT_W = $clog2(VEC_WIDTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [REQ_W-1:0] in_req_type,
  output logic                  busy,
  input  wire logic [CNT_W-1:0] count,
  input  wire dp_stat_t         stat,
  output logic [CNT_W-1:0]      idx,
  output dp_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_PIV  = 3'd2;
  localparam logic [2:0] S_ELIM = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ins_r, ins_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ins_nxt   = ins_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_CLEAR) begin
            cmd.clr  = 1'b1;
            cmd.emit = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            ins_nxt   = (in_req_type == REQ_INSERT);
            idx_nxt   = '0;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (idx_r < count) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        if (ins_r && !stat.res_zero && !stat.full) begin
          idx_nxt   = '0;
          state_nxt = S_ELIM;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ELIM: begin
        if (idx_r < count) begin
          cmd.rd_en = 1'b1;
          cmd.elim  = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_APP;
        end
      end
      S_APP: begin
        cmd.append = 1'b1;
        cmd.emit   = 1'b1;
        cmd.add    = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ins_r   <= ins_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

endmodule

`default_nettype wire

FILE: hdl/gf2eb_dpath.sv
// basis memory, residue accumulator, pivot detect and result registers
`default_nettype none

module gf2eb_dpath
  import gf2eb_pkg::*;
#(
  parameter int VEC_WIDTH = VEC_WIDTH_DEF,
  localparam int CNT_W = $clog2(VEC_WIDTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [OPERAND_W-1:0] in_operand_value,
  input  wire dp_cmd_t              cmd,
  input  wire logic [CNT_W-1:0]     idx,
  output logic [CNT_W-1:0]          count,
  output dp_stat_t                  stat,
  output logic                      out_strobe,
  output logic                      out_added,
  output logic                      out_in_span,
  output logic [OPERAND_W-1:0]      out_residue,
  output logic [RANK_W-1:0]         out_rank
);

  localparam int ADDR_W = $clog2(VEC_WIDTH);
  localparam int WORD_W = 2 * VEC_WIDTH;

  // highest set bit as a one-hot mask
  function automatic logic [VEC_WIDTH-1:0] top_onehot(input logic [VEC_WIDTH-1:0] v);
    logic [VEC_WIDTH-1:0] oh;
    for (int b = 0; b < VEC_WIDTH; b++) begin
      oh[b] = v[b] && ((v >> (b + 1)) == '0);
    end
    return oh;
  endfunction

  // word holds pivot mask above vector
  logic [WORD_W-1:0]    mem [VEC_WIDTH];
  logic [WORD_W-1:0]    rd_data_r;
  logic [ADDR_W-1:0]    rd_addr_r;
  logic                 rd_vld_r;
  logic                 rd_elim_r;
  logic [VEC_WIDTH-1:0] res_r, res_nxt;
  logic [VEC_WIDTH-1:0] piv_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic [VEC_WIDTH-1:0]           rd_vec, rd_piv, val;
  logic [VEC_WIDTH+OPERAND_W-1:0] op_ext;
  logic [OPERAND_W+VEC_WIDTH-1:0] res_ext;
  logic [CNT_W+RANK_W-1:0]        rank_ext;
  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [WORD_W-1:0]              wr_data;

  logic                 out_strobe_r;
  logic                 out_added_r;
  logic                 out_in_span_r;
  logic [OPERAND_W-1:0] out_residue_r;
  logic [RANK_W-1:0]    out_rank_r;

  assign rd_vec = rd_data_r[VEC_WIDTH-1:0];
  assign rd_piv = rd_data_r[WORD_W-1:VEC_WIDTH];
  assign op_ext = {{VEC_WIDTH{1'b0}}, in_operand_value};
  assign val    = op_ext[VEC_WIDTH-1:0];

  always_comb begin
    res_nxt = res_r;
    if (cmd.load) begin
      res_nxt = val;
    end else if (rd_vld_r && !rd_elim_r && ((res_r & rd_piv) != '0)) begin
      res_nxt = res_r ^ rd_vec;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = {rd_piv, rd_vec ^ res_r};
    if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = count_r[ADDR_W-1:0];
      wr_data = {piv_r, res_r};
    end else if (rd_vld_r && rd_elim_r && ((rd_vec & piv_r) != '0)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= idx[ADDR_W-1:0];
    rd_elim_r <= cmd.elim;
    res_r     <= res_nxt;
    piv_r     <= top_onehot(res_r);
  end

  assign res_ext  = {{OPERAND_W{1'b0}}, res_r};
  assign rank_ext = {{RANK_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_added_r   <= cmd.add;
      out_in_span_r <= !cmd.clr && (res_r == '0);
      out_residue_r <= cmd.clr ? '0 : res_ext[OPERAND_W-1:0];
      out_rank_r    <= rank_ext[RANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      rd_vld_r     <= cmd.rd_en;
      count_r      <= count_nxt;
      out_strobe_r <= cmd.emit;
    end
  end

  assign count         = count_r;
  assign stat.res_zero = (res_r == '0);
  assign stat.full     = (count_r == CNT_W'(VEC_WIDTH));
  assign out_strobe    = out_strobe_r;
  assign out_added     = out_added_r;
  assign out_in_span   = out_in_span_r;
  assign out_residue   = out_residue_r;
  assign out_rank      = out_rank_r;

endmodule

`default_nettype wire

FILE: hdl/gf2_echelon_basis.sv
// top level of the reduced echelon basis over gf(2)
//
//  channel  | ports                                          | beat taken
//  ---------+------------------------------------------------+----------------------
//  command  | start, busy, in_req_type, in_operand_value     | start high, busy low
//  result   | out_strobe, out_added, out_in_span,            | every strobe cycle
//           | out_residue, out_rank                          |
//
//  clear: result strobe in the next cycle, busy stays low
//  insert or query: a reduction pass over the stored vectors through the single
//  memory read port, and for a new vector an elimination pass, then the strobe
//  rst_n clears the rank to zero; the vector memory needs no clearing pass
//  the result is shown for one cycle only, the receiver cannot stall
`default_nettype none

module gf2_echelon_basis
  import gf2eb_pkg::*;
#(
  parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [OPERAND_W-1:0] in_operand_value,
  output logic                      out_strobe,
  output logic                      out_added,
  output logic                      out_in_span,
  output logic [OPERAND_W-1:0]      out_residue,
  output logic [RANK_W-1:0]         out_rank
);

  localparam int CNT_W = $clog2(VEC_WIDTH + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;

  gf2eb_ctrl #(
    .VEC_WIDTH(VEC_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req_type(in_req_type),
    .busy       (busy),
    .count      (count),
    .stat       (stat),
    .idx        (idx),
    .cmd        (cmd)
  );

  gf2eb_dpath #(
    .VEC_WIDTH(VEC_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operand_value(in_operand_value),
    .cmd             (cmd),
    .idx             (idx),
    .count           (count),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_added       (out_added),
    .out_in_span     (out_in_span),
    .out_residue     (out_residue),
    .out_rank        (out_rank)
  );

endmodule

`default_nettype wire

FILE: hdl/gf2eb_checker.sv
// port-level checks on the echelon basis top level, bound in
`default_nettype none

module gf2eb_checker
  import gf2eb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [REQ_W-1:0]     in_req_type,
  input wire logic                 out_strobe,
  input wire logic                 out_added,
  input wire logic                 out_in_span,
  input wire logic [OPERAND_W-1:0] out_residue,
  input wire logic [RANK_W-1:0]    out_rank
);

  // an accepted beat either starts work or is a clear answered at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted beat neither started work nor produced a result");

  // a clear produces an all-zero result in the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_CLEAR)) |=>
      (out_strobe && !out_added && !out_in_span && (out_residue == '0) && (out_rank == '0)))
    else $error("clear gave a wrong result");

  // results are only issued once the item is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

  // a vector in the span is never added
  a_span_not_added: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_in_span) |-> !out_added)
    else $error("vector in span reported as added");

endmodule

bind gf2_echelon_basis gf2eb_checker u_gf2eb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req_type(in_req_type),
  .out_strobe (out_strobe),
  .out_added  (out_added),
  .out_in_span(out_in_span),
  .out_residue(out_residue),
  .out_rank   (out_rank)
);

`default_nettype wire
